// ----- hw/rtl/cfsg_pkg.sv -----
// Shared types and constants for the filled-circle span generator.
// Used by the channel interfaces and by the core; depends on nothing else.
package cfsg_pkg;

    localparam int MaxRadius = 31;

    localparam int CoordW    = 12;
    localparam int RadiusW   = 5;
    localparam int AlphaW    = 16;
    localparam int OffsetW   = 6;
    localparam int LengthW   = 6;
    localparam int AddrW     = 32;
    localparam int StrideW   = 17;
    localparam int DecisionW = 9;
    localparam int WalkW     = 6;
    localparam int RowW      = 14;
    localparam int ProductW  = RowW + StrideW;

    localparam int ApbAddrW  = 4;
    localparam int ApbDataW  = 32;

    localparam logic [1:0] RegBaseAddress = 2'd0;
    localparam logic [1:0] RegRowStride   = 2'd1;
    localparam logic [1:0] RegPixelFormat = 2'd2;

    localparam logic FmtRgba8  = 1'b0;
    localparam logic FmtRgba16 = 1'b1;

    localparam logic [AlphaW-1:0] OpaqueRgba8  = AlphaW'(255);
    localparam logic [AlphaW-1:0] OpaqueRgba16 = AlphaW'(65535);

    // Byte-per-pixel scaling as shift amounts: 4 and 8 bytes.
    localparam int Bpp4Shift = 2;
    localparam int Bpp8Shift = 3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_ADD
    } t_state;

    typedef enum logic [2:0] {
        PH_CENTER,
        PH_XNEG,
        PH_XPOS,
        PH_YNEG,
        PH_YPOS
    } t_phase;

endpackage

// ----- hw/rtl/cfsg_req_if.sv -----
// Valid/ready channel that carries one circle request transaction.
// Depends on cfsg_pkg for the field widths.
interface cfsg_req_if;
    import cfsg_pkg::*;

    logic                valid;
    logic                ready;
    logic [CoordW-1:0]   center_x;
    logic [CoordW-1:0]   center_y;
    logic [RadiusW-1:0]  circle_radius;
    logic [AlphaW-1:0]   colour_alpha;

    modport source (
        output valid, center_x, center_y, circle_radius, colour_alpha,
        input  ready
    );

    modport sink (
        input  valid, center_x, center_y, circle_radius, colour_alpha,
        output ready
    );

endinterface

// ----- hw/rtl/cfsg_span_if.sv -----
// Valid/ready channel that carries one span transaction.
// Depends on cfsg_pkg for the field widths.
interface cfsg_span_if;
    import cfsg_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [OffsetW-1:0]  offset_x;
    logic signed [OffsetW-1:0]  offset_y;
    logic [LengthW-1:0]         span_length;
    logic [AddrW-1:0]           span_address;
    logic                       blend_over;
    logic                       last_span;

    modport source (
        output valid, offset_x, offset_y, span_length, span_address, blend_over,
               last_span,
        input  ready
    );

    modport sink (
        input  valid, offset_x, offset_y, span_length, span_address, blend_over,
               last_span,
        output ready
    );

endinterface

// ----- hw/rtl/circle_fill_span_generator_core.sv -----
// Filled-circle span generator top level: APB register file, midpoint walk
// sequencer and the shared multiply/add address unit.
// Depends on cfsg_pkg, cfsg_req_if and cfsg_span_if.
//
// A request of radius r yields 2*r+1 span transactions, the center row first and
// the last one flagged. Each span passes through the single shared unit as a
// row times stride multiply in S_MUL and then an address add in S_ADD. The
// request channel is ready only while the sequencer is idle; the final span
// sits in the output register while the next request is already taken. The
// user must write the registers only while no request is in flight; the block
// itself does not enforce it.
module circle_fill_span_generator_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    cfsg_req_if.sink                         i_req,
    cfsg_span_if.source                      o_span,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [cfsg_pkg::ApbAddrW-1:0]    paddr,
    input  logic [cfsg_pkg::ApbDataW-1:0]    pwdata,
    output logic [cfsg_pkg::ApbDataW-1:0]    prdata,
    output logic                             pready
);
    import cfsg_pkg::*;

    logic [AddrW-1:0]            r_base_address;
    logic signed [StrideW-1:0]   r_row_stride;
    logic                        r_pixel_format;
    logic [1:0]                  w_reg_index;
    logic                        w_reg_write;

    t_state                      r_state, n_state;
    t_phase                      r_phase, n_phase;
    logic [WalkW-1:0]            r_x, n_x;
    logic [WalkW-1:0]            r_y, n_y;
    logic signed [DecisionW-1:0] r_f, n_f;
    logic [CoordW-1:0]           r_cx, n_cx;
    logic [CoordW-1:0]           r_cy, n_cy;
    logic                        r_bpp8, n_bpp8;
    logic                        r_blend, n_blend;

    logic signed [OffsetW-1:0]   r_ox, n_ox;
    logic signed [OffsetW-1:0]   r_oy, n_oy;
    logic [LengthW-1:0]          r_len, n_len;
    logic signed [RowW-1:0]      r_col, n_col;
    logic [AddrW-1:0]            r_prod, n_prod;

    logic                        r_out_valid, n_out_valid;
    logic signed [OffsetW-1:0]   r_out_ox, n_out_ox;
    logic signed [OffsetW-1:0]   r_out_oy, n_out_oy;
    logic [LengthW-1:0]          r_out_len, n_out_len;
    logic [AddrW-1:0]            r_out_addr, n_out_addr;
    logic                        r_out_blend, n_out_blend;
    logic                        r_out_last, n_out_last;

    logic [RadiusW-1:0]          w_rad;
    logic signed [RowW-1:0]      w_row;
    logic signed [ProductW-1:0]  w_product;
    logic signed [AddrW-1:0]     w_col_ext;
    logic [AddrW-1:0]            w_col_term;
    logic                        w_more;
    logic                        w_last;
    logic signed [DecisionW-1:0] w_x9;
    logic signed [DecisionW-1:0] w_y9;
    logic signed [DecisionW-1:0] w_f_inward;
    logic signed [DecisionW-1:0] w_f_keep;

    // Configuration port.
    assign pready      = 1'b1;
    assign w_reg_index = paddr[ApbAddrW-1:2];
    assign w_reg_write = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_address <= '0;
            r_row_stride   <= '0;
            r_pixel_format <= FmtRgba8;
        end else if (w_reg_write) begin
            case (w_reg_index)
                RegBaseAddress: r_base_address <= pwdata[AddrW-1:0];
                RegRowStride:   r_row_stride   <= $signed(pwdata[StrideW-1:0]);
                RegPixelFormat: r_pixel_format <= pwdata[0];
                default:        ;
            endcase
        end
    end

    always_comb begin
        case (w_reg_index)
            RegBaseAddress: prdata = r_base_address;
            RegRowStride:   prdata = ApbDataW'(r_row_stride);
            RegPixelFormat: prdata = {{(ApbDataW-1){1'b0}}, r_pixel_format};
            default:        prdata = '0;
        endcase
    end

    // Shared datapath terms.
    assign w_rad      = (i_req.circle_radius > RadiusW'(MaxRadius)) ?
                        RadiusW'(MaxRadius) : i_req.circle_radius;
    assign w_product  = w_row * r_row_stride;
    assign w_col_ext  = AddrW'(r_col);
    assign w_col_term = r_bpp8 ? AddrW'(w_col_ext <<< Bpp8Shift)
                               : AddrW'(w_col_ext <<< Bpp4Shift);
    assign w_more     = r_x > r_y;
    assign w_last     = ((r_phase == PH_CENTER) || (r_phase == PH_YPOS)) && !w_more;
    assign w_x9       = $signed({{(DecisionW-WalkW){1'b0}}, r_x});
    assign w_y9       = $signed({{(DecisionW-WalkW){1'b0}}, r_y});
    assign w_f_keep   = r_f + ((w_y9 + DecisionW'(1)) <<< 1) + DecisionW'(1);
    assign w_f_inward = w_f_keep - ((w_x9 - DecisionW'(1)) <<< 1);

    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_x         = r_x;
        n_y         = r_y;
        n_f         = r_f;
        n_cx        = r_cx;
        n_cy        = r_cy;
        n_bpp8      = r_bpp8;
        n_blend     = r_blend;
        n_ox        = r_ox;
        n_oy        = r_oy;
        n_len       = r_len;
        n_col       = r_col;
        n_prod      = r_prod;
        n_out_valid = r_out_valid && !o_span.ready;
        n_out_ox    = r_out_ox;
        n_out_oy    = r_out_oy;
        n_out_len   = r_out_len;
        n_out_addr  = r_out_addr;
        n_out_blend = r_out_blend;
        n_out_last  = r_out_last;
        w_row       = $signed({{(RowW-CoordW){1'b0}}, r_cy});

        case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_cx    = i_req.center_x;
                    n_cy    = i_req.center_y;
                    n_x     = WalkW'(w_rad);
                    n_y     = '0;
                    n_f     = DecisionW'(1) - $signed({{(DecisionW-RadiusW){1'b0}}, w_rad});
                    n_phase = PH_CENTER;
                    if (r_pixel_format == FmtRgba16) begin
                        n_bpp8  = 1'b1;
                        n_blend = i_req.colour_alpha < OpaqueRgba16;
                    end else begin
                        n_bpp8  = 1'b0;
                        n_blend = i_req.colour_alpha < OpaqueRgba8;
                    end
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                case (r_phase)
                    PH_XNEG: begin
                        n_ox  = -$signed(r_y);
                        n_oy  = -$signed(r_x);
                        n_len = {r_y[WalkW-2:0], 1'b1};
                    end
                    PH_XPOS: begin
                        n_ox  = -$signed(r_y);
                        n_oy  = $signed(r_x);
                        n_len = {r_y[WalkW-2:0], 1'b1};
                    end
                    PH_YNEG: begin
                        n_ox  = -$signed(r_x);
                        n_oy  = -$signed(r_y);
                        n_len = {r_x[WalkW-2:0], 1'b1};
                    end
                    PH_YPOS: begin
                        n_ox  = -$signed(r_x);
                        n_oy  = $signed(r_y);
                        n_len = {r_x[WalkW-2:0], 1'b1};
                    end
                    default: begin
                        n_ox  = -$signed(r_x);
                        n_oy  = '0;
                        n_len = {r_x[WalkW-2:0], 1'b1};
                    end
                endcase
                w_row   = $signed({{(RowW-CoordW){1'b0}}, r_cy}) + RowW'(n_oy);
                n_col   = $signed({{(RowW-CoordW){1'b0}}, r_cx}) + RowW'(n_ox);
                n_prod  = AddrW'(w_product);
                n_state = S_ADD;
            end
            S_ADD: begin
                if (!r_out_valid || o_span.ready) begin
                    n_out_valid = 1'b1;
                    n_out_ox    = r_ox;
                    n_out_oy    = r_oy;
                    n_out_len   = r_len;
                    n_out_addr  = r_base_address + r_prod + w_col_term;
                    n_out_blend = r_blend;
                    n_out_last  = w_last;
                    n_state     = w_last ? S_IDLE : S_MUL;
                    case (r_phase)
                        PH_XNEG: n_phase = PH_XPOS;
                        PH_XPOS: begin
                            n_x     = r_x - WalkW'(1);
                            n_y     = r_y + WalkW'(1);
                            n_f     = w_f_inward;
                            n_phase = PH_YNEG;
                        end
                        PH_YNEG: n_phase = PH_YPOS;
                        default: begin
                            if (w_more) begin
                                if (!r_f[DecisionW-1]) begin
                                    if ((r_x - WalkW'(1)) != r_y) begin
                                        n_phase = PH_XNEG;
                                    end else begin
                                        n_x     = r_x - WalkW'(1);
                                        n_y     = r_y + WalkW'(1);
                                        n_f     = w_f_inward;
                                        n_phase = PH_YNEG;
                                    end
                                end else begin
                                    n_y     = r_y + WalkW'(1);
                                    n_f     = w_f_keep;
                                    n_phase = PH_YNEG;
                                end
                            end
                        end
                    endcase
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= PH_CENTER;
            r_x         <= '0;
            r_y         <= '0;
            r_f         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_x         <= n_x;
            r_y         <= n_y;
            r_f         <= n_f;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cx        <= n_cx;
        r_cy        <= n_cy;
        r_bpp8      <= n_bpp8;
        r_blend     <= n_blend;
        r_ox        <= n_ox;
        r_oy        <= n_oy;
        r_len       <= n_len;
        r_col       <= n_col;
        r_prod      <= n_prod;
        r_out_ox    <= n_out_ox;
        r_out_oy    <= n_out_oy;
        r_out_len   <= n_out_len;
        r_out_addr  <= n_out_addr;
        r_out_blend <= n_out_blend;
        r_out_last  <= n_out_last;
    end

    assign i_req.ready         = (r_state == S_IDLE);
    assign o_span.valid        = r_out_valid;
    assign o_span.offset_x     = r_out_ox;
    assign o_span.offset_y     = r_out_oy;
    assign o_span.span_length  = r_out_len;
    assign o_span.span_address = r_out_addr;
    assign o_span.blend_over   = r_out_blend;
    assign o_span.last_span    = r_out_last;

    // Every span is centered on the circle's column axis.
    a_span_centered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_span.valid |-> o_span.span_length[0] &&
        ((o_span.offset_x + OffsetW'({1'b0, o_span.span_length[LengthW-1:1]})) == '0))
        else $error("span not symmetric about the center column");

    // The final span of a circle lies on or below the center row.
    a_last_below: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_span.valid && o_span.last_span) |-> !o_span.offset_y[OffsetW-1])
        else $error("last span lies above the center row");

    // A request transaction closes the request channel until its walk ends.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !i_req.ready)
        else $error("request channel open right after a request was taken");

    // The walk never runs past the diagonal while spans remain.
    a_walk_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL) |-> (r_y <= r_x) || (r_phase == PH_YNEG) || (r_phase == PH_YPOS))
        else $error("midpoint walk crossed the diagonal");

endmodule

// ----- verif/circle_fill_span_generator_core_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for circle_fill_span_generator_core: drives circle requests and
// APB register writes, predicts every span of each circle and checks each span transaction.
// Depends on cfsg_pkg, cfsg_req_if, cfsg_span_if and the core RTL.
module circle_fill_span_generator_core_tb;
    import cfsg_pkg::*;

    typedef struct packed {
        logic [OffsetW-1:0] offset_x;
        logic [OffsetW-1:0] offset_y;
        logic [LengthW-1:0] span_length;
        logic [AddrW-1:0]   span_address;
        logic               blend_over;
        logic               last_span;
    } t_span;

    logic                i_clk;
    logic                i_rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ApbAddrW-1:0] paddr;
    logic [ApbDataW-1:0] pwdata;
    logic [ApbDataW-1:0] prdata;
    logic                pready;

    cfsg_req_if  req_ch ();
    cfsg_span_if span_ch ();

    circle_fill_span_generator_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_span  (span_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    t_span               expected_spans[$];
    logic [AddrW-1:0]    surf_base;
    logic [StrideW-1:0]  surf_stride;
    logic                surf_format;
    int                  error_count;
    int                  circles_sent;
    int                  spans_checked;
    int                  settings_used;
    int                  span_hold_cycles;
    bit                  req_offered;
    bit                  req_gaps_on;
    bit                  span_stalls_on;
    logic [AlphaW-1:0]   alpha_marks[5] = '{16'd254, 16'd255, 16'd256, 16'd65534, 16'd65535};

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        error_count++;
        if (error_count <= 40) begin
            $display("[%0t] mismatch in %s: got 0x%08h, expected 0x%08h",
                     $realtime, what, got, want);
        end
    endtask

    function automatic void add_span(input logic [CoordW-1:0] cx, input logic [CoordW-1:0] cy,
                                     input int ox, input int oy, input int len,
                                     input logic [3:0] bpp, input logic blend);
        t_span       s;
        logic [31:0] row;
        logic [31:0] col;
        logic [31:0] stride_ext;
        row = {20'd0, cy} + 32'(oy);
        col = {20'd0, cx} + 32'(ox);
        stride_ext = {{(32 - StrideW){surf_stride[StrideW-1]}}, surf_stride};
        s.offset_x = OffsetW'(ox);
        s.offset_y = OffsetW'(oy);
        s.span_length = LengthW'(len);
        s.span_address = surf_base + row * stride_ext + col * {28'd0, bpp};
        s.blend_over = blend;
        s.last_span = 1'b0;
        expected_spans.push_back(s);
    endfunction

    // Midpoint walk: center row first, then the (-x, +x) pair when x steps in and x-1 differs from y, then (-y, +y).
    function automatic void predict_circle_spans(input logic [CoordW-1:0] cx,
                                                 input logic [CoordW-1:0] cy,
                                                 input logic [RadiusW-1:0] r,
                                                 input logic [AlphaW-1:0] alpha);
        int          rad;
        int          f;
        int          wx;
        int          wy;
        logic [3:0]  bpp;
        logic        blend;
        t_span       tail;
        rad = (r > MaxRadius) ? MaxRadius : int'(r);
        if (surf_format == FmtRgba16) begin
            bpp = 4'd8;
            blend = alpha < OpaqueRgba16;
        end else begin
            bpp = 4'd4;
            blend = alpha < OpaqueRgba8;
        end
        f = 1 - rad;
        wx = rad;
        wy = 0;
        add_span(cx, cy, -rad, 0, 2 * rad + 1, bpp, blend);
        while (wx > wy) begin
            if (f >= 0) begin
                if (wx - 1 != wy) begin
                    add_span(cx, cy, -wy, -wx, 2 * wy + 1, bpp, blend);
                    add_span(cx, cy, -wy, wx, 2 * wy + 1, bpp, blend);
                end
                wx--;
                f -= 2 * wx;
            end
            wy++;
            f += 2 * wy + 1;
            add_span(cx, cy, -wx, -wy, 2 * wx + 1, bpp, blend);
            add_span(cx, cy, -wx, wy, 2 * wx + 1, bpp, blend);
        end
        tail = expected_spans.pop_back();
        tail.last_span = 1'b1;
        expected_spans.push_back(tail);
    endfunction

    task automatic release_request();
        if (req_offered) begin
            req_ch.valid <= 1'b0;
            req_offered = 1'b0;
        end
    endtask

    task automatic send_circle(input logic [CoordW-1:0] cx, input logic [CoordW-1:0] cy,
                               input logic [RadiusW-1:0] r, input logic [AlphaW-1:0] alpha);
        int gap;
        gap = req_gaps_on ? $urandom_range(0, 12) : 0;
        if (gap > 0) begin
            release_request();
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.center_x <= cx;
        req_ch.center_y <= cy;
        req_ch.circle_radius <= r;
        req_ch.colour_alpha <= alpha;
        req_offered = 1'b1;
        do @(posedge i_clk); while (!req_ch.ready);
        predict_circle_spans(cx, cy, r, alpha);
        circles_sent++;
    endtask

    task automatic wait_for_spans();
        release_request();
        while (expected_spans.size() != 0) @(posedge i_clk);
    endtask

    task automatic apb_access(input bit write, input logic [1:0] reg_index,
                              input logic [31:0] wdata, output logic [31:0] rdata);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= write;
        paddr <= ApbAddrW'({reg_index, 2'b00});
        pwdata <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic configure_surface(input logic [AddrW-1:0] base,
                                     input logic [StrideW-1:0] stride, input logic fmt);
        logic [31:0] readback;
        wait_for_spans();
        repeat (8) @(posedge i_clk);
        apb_access(1'b1, RegBaseAddress, base, readback);
        apb_access(1'b1, RegRowStride, {{(32 - StrideW){stride[StrideW-1]}}, stride}, readback);
        apb_access(1'b1, RegPixelFormat, {31'd0, fmt}, readback);
        surf_base = base;
        surf_stride = stride;
        surf_format = fmt;
        apb_access(1'b0, RegBaseAddress, '0, readback);
        if (readback !== base) report_mismatch("base_address readback", readback, base);
        apb_access(1'b0, RegRowStride, '0, readback);
        if (readback[StrideW-1:0] !== stride) begin
            report_mismatch("row_stride readback", readback, 32'(stride));
        end
        apb_access(1'b0, RegPixelFormat, '0, readback);
        if (readback[0] !== fmt) report_mismatch("pixel_format readback", readback, 32'(fmt));
        settings_used++;
    endtask

    task automatic send_random_circle();
        logic [CoordW-1:0]  cx;
        logic [CoordW-1:0]  cy;
        logic [RadiusW-1:0] r;
        logic [AlphaW-1:0]  alpha;
        int                 pick;
        cx = CoordW'($urandom_range(0, 4095));
        cy = CoordW'($urandom_range(0, 4095));
        if ($urandom_range(0, 7) == 0) cx = $urandom_range(0, 1) ? 12'd4095 : 12'd0;
        if ($urandom_range(0, 7) == 0) cy = $urandom_range(0, 1) ? 12'd4095 : 12'd0;
        pick = $urandom_range(0, 19);
        if (pick < 14) r = RadiusW'($urandom_range(0, 6));
        else if (pick < 19) r = RadiusW'($urandom_range(7, 20));
        else r = RadiusW'($urandom_range(21, 31));
        case ($urandom_range(0, 3))
            0: alpha = AlphaW'($urandom_range(0, 255));
            1: alpha = alpha_marks[3'($urandom_range(0, 4))];
            default: alpha = AlphaW'($urandom_range(0, 65535));
        endcase
        send_circle(cx, cy, r, alpha);
    endtask

    task automatic test_reset_defaults();
        send_circle(12'd0, 12'd0, 5'd0, 16'd0);
        send_circle(12'd4095, 12'd4095, 5'd1, 16'd65535);
    endtask

    task automatic test_radius_extremes();
        configure_surface(32'h0010_0000, 17'd16384, FmtRgba8);
        send_circle(12'd100, 12'd200, 5'd0, 16'd128);
        send_circle(12'd0, 12'd0, 5'd1, 16'd255);
        send_circle(12'd4095, 12'd0, 5'd2, 16'd7);
        send_circle(12'd2048, 12'd2048, 5'd31, 16'd300);
    endtask

    task automatic test_alpha_thresholds();
        configure_surface(32'h0000_4000, 17'd2048, FmtRgba8);
        send_circle(12'd50, 12'd60, 5'd3, 16'd0);
        send_circle(12'd50, 12'd60, 5'd3, 16'd254);
        send_circle(12'd50, 12'd60, 5'd3, 16'd255);
        send_circle(12'd50, 12'd60, 5'd3, 16'd256);
        configure_surface(32'h0000_4000, 17'd4096, FmtRgba16);
        send_circle(12'd70, 12'd80, 5'd4, 16'd255);
        send_circle(12'd70, 12'd80, 5'd4, 16'd65534);
        send_circle(12'd70, 12'd80, 5'd4, 16'd65535);
    endtask

    task automatic test_address_wrap();
        configure_surface(32'hFFFF_FF00, 17'h0FFFF, FmtRgba16);
        send_circle(12'd4095, 12'd4095, 5'd31, 16'h8000);
        configure_surface(32'h0000_0000, 17'h10000, FmtRgba8);
        send_circle(12'd0, 12'd0, 5'd31, 16'hFFFF);
        send_circle(12'd4095, 12'd0, 5'd17, 16'd3);
    endtask

    task automatic test_output_backpressure();
        configure_surface(32'h2000_0000, 17'd8192, FmtRgba8);
        req_gaps_on = 1'b0;
        span_hold_cycles = 400;
        repeat (24) send_random_circle();
        req_gaps_on = 1'b1;
    endtask

    task automatic test_paused_sender();
        repeat (10) send_random_circle();
        wait_for_spans();
        repeat (10) send_random_circle();
    endtask

    task automatic test_random_settings();
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: configure_surface(32'h0000_0000, 17'd0, FmtRgba8);
                1: configure_surface(32'hFFFF_FFFF, 17'h10000, FmtRgba16);
                default: configure_surface($urandom, StrideW'($urandom_range(0, 131071)),
                                           1'($urandom_range(0, 1)));
            endcase
            req_gaps_on = (phase % 3 == 0) || (phase % 3 == 2 && $urandom_range(0, 1) == 1);
            span_stalls_on = (phase % 3 == 0) || (phase % 3 == 2 && $urandom_range(0, 1) == 0);
            repeat (65) send_random_circle();
        end
        req_gaps_on = 1'b1;
        span_stalls_on = 1'b1;
    endtask

    initial begin : span_receiver
        int stall;
        span_ch.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            stall = span_stalls_on ? $urandom_range(0, 12) : 0;
            stall += span_hold_cycles;
            span_hold_cycles = 0;
            if (stall > 0) begin
                span_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            span_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!span_ch.valid);
        end
    end

    always @(posedge i_clk) begin : span_checker
        t_span want;
        if (i_rst_n && span_ch.valid && span_ch.ready) begin
            spans_checked++;
            if (expected_spans.size() == 0) begin
                report_mismatch("span with no circle pending", span_ch.span_address, '0);
            end else begin
                want = expected_spans.pop_front();
                if (span_ch.offset_x !== want.offset_x) begin
                    report_mismatch("offset_x", 32'($unsigned(span_ch.offset_x)),
                                    32'(want.offset_x));
                end
                if (span_ch.offset_y !== want.offset_y) begin
                    report_mismatch("offset_y", 32'($unsigned(span_ch.offset_y)),
                                    32'(want.offset_y));
                end
                if (span_ch.span_length !== want.span_length) begin
                    report_mismatch("span_length", 32'(span_ch.span_length),
                                    32'(want.span_length));
                end
                if (span_ch.span_address !== want.span_address) begin
                    report_mismatch("span_address", span_ch.span_address, want.span_address);
                end
                if (span_ch.blend_over !== want.blend_over) begin
                    report_mismatch("blend_over", 32'(span_ch.blend_over),
                                    32'(want.blend_over));
                end
                if (span_ch.last_span !== want.last_span) begin
                    report_mismatch("last_span", 32'(span_ch.last_span), 32'(want.last_span));
                end
            end
        end
    end

    initial begin : stimulus
        req_ch.valid <= 1'b0;
        req_ch.center_x <= '0;
        req_ch.center_y <= '0;
        req_ch.circle_radius <= '0;
        req_ch.colour_alpha <= '0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        i_rst_n <= 1'b0;
        surf_base = '0;
        surf_stride = '0;
        surf_format = FmtRgba8;
        req_gaps_on = 1'b1;
        span_stalls_on = 1'b1;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_defaults();
        test_radius_extremes();
        test_alpha_thresholds();
        test_address_wrap();
        test_output_backpressure();
        test_paused_sender();
        test_random_settings();
        wait_for_spans();
        repeat (16) @(posedge i_clk);
        $display("Sent %0d circles under %0d register settings; %0d span transactions compared.",
                 circles_sent, settings_used, spans_checked);
        $display("Radii 0 to 31, both pixel formats, alpha thresholds, address wrap and stalls.");
        if (error_count == 0) begin
            $display("circle_fill_span_generator_core test passed");
        end else begin
            $display("circle_fill_span_generator_core test failed");
        end
        $finish;
    end

    initial begin : watchdog
        #30_000_000;
        $display("circle_fill_span_generator_core test failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/cfsg_pkg.sv
hw/rtl/cfsg_req_if.sv
hw/rtl/cfsg_span_if.sv
hw/rtl/circle_fill_span_generator_core.sv
verif/circle_fill_span_generator_core_tb.sv
